/* rtl/sitd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sitd_pkg: shared types and constants
// Widths, ASCII codes, cell operations and controller states for the
// signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package sitd_pkg;

  localparam int MaxBuffer  = 32;                   // largest buffer, bytes
  localparam int IdxW       = $clog2(MaxBuffer);    // byte index width
  localparam int ValueW     = 32;
  localparam int NumDigits  = 10;                   // decimal digits of 2^31
  localparam int NdigW      = 4;                    // holds 0..NumDigits
  localparam int BitCntW    = $clog2(ValueW);
  localparam int CfgW       = 6;

  localparam logic [CfgW-1:0] CfgReset   = 6'd16;
  localparam logic [7:0]      AsciiZero  = 8'h30;
  localparam logic [7:0]      AsciiMinus = 8'h2D;
  localparam logic [7:0]      AsciiNul   = 8'h00;

  typedef enum logic [1:0] {
    CELL_HOLD,    // keep digit
    CELL_CLEAR,   // digit to zero
    CELL_DABBLE,  // add 3 if >= 5, then shift in lower neighbor's carry
    CELL_MOVE     // take lower neighbor's digit
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_EMIT
  } state_e;

endpackage
`default_nettype wire

/* rtl/sitd_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sitd_cell: one BCD digit cell
// Holds one decimal digit; does a double-dabble step or a digit move with
// its lower neighbor.
// ----------------------------------------------------------------------------
module sitd_cell
  import sitd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_op_e   op_i,
  input  wire logic       carry_i,
  input  wire logic [3:0] digit_i,
  output logic            carry_o,
  output logic [3:0]      digit_o
);

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  always_comb begin
    adj = (digit_q >= 4'd5) ? 4'(digit_q + 4'd3) : digit_q;
    digit_d = digit_q;
    case (op_i)
      CELL_HOLD:   digit_d = digit_q;
      CELL_CLEAR:  digit_d = 4'd0;
      CELL_DABBLE: digit_d = {adj[2:0], carry_i};
      CELL_MOVE:   digit_d = digit_i;
      default:     digit_d = digit_q;
    endcase
  end

  // digit register is payload; reset only for clean simulation start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= 4'd0;
    end else begin
      digit_q <= digit_d;
    end
  end

  assign carry_o = adj[3];
  assign digit_o = digit_q;

endmodule
`default_nettype wire

/* rtl/signed_int_to_decimal_text.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_text: signed 32-bit integer to fixed-size ASCII buffer
// Double-dabble through a row of BCD cells, then byte-serial output.
// ----------------------------------------------------------------------------
// Each accepted item (a signed 32-bit value) produces exactly buffer_size
// bytes (clamped to 1..32; zero counts as 1), one per output item, with
// last_o on the final byte: optional '-', the decimal digits most
// significant first, a NUL, then zero padding. Text longer than
// buffer_size-1 bytes is cut on the right. An item goes through the accept
// cycle, conversion (one value bit per cycle through the ten digit cells),
// removal of up to 9 leading zeros, a step that starts output, then the
// output of its buffer_size bytes. One item is in work at a time; the
// next is accepted while the final byte still waits in the output register.
// buffer_size is written through cfg_we_i / cfg_wdata_i; the user must write it
// only while idle, the block itself does not enforce it.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_text
  import sitd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration
  input  wire logic              cfg_we_i,
  input  wire logic [CfgW-1:0]   cfg_wdata_i,
  // input items
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic signed [ValueW-1:0] value_i,
  // output items
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [7:0]             char_byte_o,
  output logic                   last_o
);

  state_e state_q, state_d;

  logic [CfgW-1:0]    cfg_q;
  logic [IdxW-1:0]    last_idx;      // effective size - 1

  logic [ValueW-1:0]  mag_q, mag_d;
  logic               neg_q, neg_d;
  logic [BitCntW-1:0] bit_cnt_q, bit_cnt_d;
  logic [NdigW-1:0]   ndig_q, ndig_d;
  logic [NdigW-1:0]   rem_q, rem_d;   // text bytes still to send
  logic               sign_q, sign_d; // minus still to send
  logic [IdxW-1:0]    cnt_q, cnt_d;   // byte position

  logic               out_valid_q, out_valid_d;
  logic [7:0]         char_q, char_d;
  logic               last_q, last_d;

  logic [NdigW-1:0]   text_len;
  logic               load;
  cell_op_e           cell_op;

  // digit chain: index 0 feeds the lowest cell, NumDigits is the top cell
  logic               carry_w [NumDigits+1];
  logic [3:0]         digit_w [NumDigits+1];

  assign carry_w[0] = mag_q[ValueW-1];
  assign digit_w[0] = 4'd0;

  for (genvar k = 0; k < NumDigits; k++) begin : g_cell
    sitd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (cell_op),
      .carry_i (carry_w[k]),
      .digit_i (digit_w[k]),
      .carry_o (carry_w[k+1]),
      .digit_o (digit_w[k+1])
    );
  end

  // effective size: zero -> 1, above MaxBuffer -> MaxBuffer
  always_comb begin
    if (cfg_q == '0) begin
      last_idx = '0;
    end else if (int'(cfg_q) > MaxBuffer) begin
      last_idx = IdxW'(MaxBuffer - 1);
    end else begin
      last_idx = IdxW'(cfg_q - 1'b1);
    end
  end

  assign text_len   = NdigW'(ndig_q + {{(NdigW-1){1'b0}}, neg_q});
  assign in_stall_o = (state_q != ST_IDLE);
  assign load       = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    bit_cnt_d   = bit_cnt_q;
    ndig_d      = ndig_q;
    rem_d       = rem_q;
    sign_d      = sign_q;
    cnt_d       = cnt_q;
    cell_op     = CELL_HOLD;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    last_d      = last_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          neg_d     = value_i[ValueW-1];
          mag_d     = value_i[ValueW-1] ? ValueW'(-value_i) : value_i;
          bit_cnt_d = '0;
          cell_op   = CELL_CLEAR;
          state_d   = ST_CONV;
        end
      end
      ST_CONV: begin
        cell_op   = CELL_DABBLE;
        mag_d     = {mag_q[ValueW-2:0], 1'b0};
        bit_cnt_d = BitCntW'(bit_cnt_q + 1'b1);
        if (bit_cnt_q == BitCntW'(ValueW - 1)) begin
          ndig_d  = NdigW'(NumDigits);
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        // drop leading zeros, keep at least one digit
        if (digit_w[NumDigits] == 4'd0 && ndig_q > NdigW'(1)) begin
          cell_op = CELL_MOVE;
          ndig_d  = NdigW'(ndig_q - 1'b1);
        end else begin
          rem_d   = (int'(text_len) < int'(last_idx)) ? text_len : NdigW'(last_idx);
          sign_d  = neg_q;
          cnt_d   = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_d = 1'b1;
          last_d      = (cnt_q == last_idx);
          if (rem_q == '0) begin
            char_d = AsciiNul;
          end else if (sign_q) begin
            char_d = AsciiMinus;
            sign_d = 1'b0;
            rem_d  = NdigW'(rem_q - 1'b1);
          end else begin
            char_d  = 8'(AsciiZero + {4'd0, digit_w[NumDigits]});
            cell_op = CELL_MOVE;
            rem_d   = NdigW'(rem_q - 1'b1);
          end
          cnt_d = IdxW'(cnt_q + 1'b1);
          if (cnt_q == last_idx) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= CfgReset;
      out_valid_q <= 1'b0;
      bit_cnt_q   <= '0;
      ndig_q      <= '0;
      rem_q       <= '0;
      sign_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      bit_cnt_q   <= bit_cnt_d;
      ndig_q      <= ndig_d;
      rem_q       <= rem_d;
      sign_q      <= sign_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_byte_o = char_q;
  assign last_o      = last_q;

  // ten digits always hold a 32-bit magnitude: nothing leaves the top cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |-> !carry_w[NumDigits])
    else $error("digit chain overflow");

  // at least one digit survives normalization
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NORM) |-> (ndig_q != '0))
    else $error("digit count hit zero");

  // a stalled output item stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=>
      (out_valid_q && $stable(char_q) && $stable(last_q)))
    else $error("stalled output item changed");

  // byte position never passes the end of the buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (cnt_q <= last_idx))
    else $error("byte position past buffer end");

endmodule
`default_nettype wire
